/* design/dsc_pkg.sv */
// Shared types, constants and digit helpers for the debounced stopwatch control.
package dsc_pkg;

  localparam int unsigned ButtonCount = 4;

  // Button positions in the raw and stable vectors
  localparam int unsigned BtnInc    = 0;
  localparam int unsigned BtnDec    = 1;
  localparam int unsigned BtnClear  = 2;
  localparam int unsigned BtnToggle = 3;

  // Item operation codes
  localparam logic OpPoll = 1'b0;
  localparam logic OpTick = 1'b1;

  localparam logic [7:0] LimitReset  = 8'd5;
  localparam logic [7:0] AgeMax      = 8'd255;
  localparam logic [5:0] SecMax      = 6'd59;
  localparam logic [4:0] TicksPerSec = 5'd20;

  // Per-lane debounce status handed to the merging stage
  typedef struct packed {
    logic press;
    logic stable;
  } lane_status_t;

  // Digits and run flag coming out of the count core
  typedef struct packed {
    logic [2:0] seconds_tens;
    logic [3:0] seconds_ones;
    logic [3:0] tenths_digit;
    logic [3:0] hundredths_digit;
    logic       running;
  } count_digits_t;

  // Full result item
  typedef struct packed {
    count_digits_t              digits;
    logic [ButtonCount-1:0]     stable_buttons;
  } result_t;

  // Tens digit of a seconds value in 0..59
  function automatic logic [2:0] sec_tens(input logic [5:0] sec);
    logic [2:0] tens;
    if (sec >= 6'd50) begin
      tens = 3'd5;
    end else if (sec >= 6'd40) begin
      tens = 3'd4;
    end else if (sec >= 6'd30) begin
      tens = 3'd3;
    end else if (sec >= 6'd20) begin
      tens = 3'd2;
    end else if (sec >= 6'd10) begin
      tens = 3'd1;
    end else begin
      tens = 3'd0;
    end
    return tens;
  endfunction

endpackage

/* design/dsc_if.sv */
// Valid/ready stream interfaces for input and result items.
interface dsc_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [3:0] raw_buttons;

  modport source (output valid, output op, output raw_buttons, input ready);
  modport sink (input valid, input op, input raw_buttons, output ready);
endinterface

interface dsc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] seconds_tens;
  logic [3:0] seconds_ones;
  logic [3:0] tenths_digit;
  logic [3:0] hundredths_digit;
  logic       running;
  logic [3:0] stable_buttons;

  modport source (output valid, output seconds_tens, output seconds_ones,
                  output tenths_digit, output hundredths_digit, output running,
                  output stable_buttons, input ready);
  modport sink (input valid, input seconds_tens, input seconds_ones,
                input tenths_digit, input hundredths_digit, input running,
                input stable_buttons, output ready);
endinterface

/* design/dsc_debounce_lane.sv */
// One button lane: age counter, stable level and held flag.
module dsc_debounce_lane
  import dsc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         poll_i,
  input  logic         raw_i,
  input  logic [7:0]   limit_i,
  output lane_status_t status_o
);

  logic       last_q, last_d;
  logic       stable_q, stable_d;
  logic       held_q, held_d;
  logic [7:0] age_q, age_d;
  logic       held_rel;
  logic       press;

  // Age, level acceptance and press detection for this poll
  always_comb begin
    if (raw_i != last_q) begin
      age_d = 8'd0;
    end else if (age_q < AgeMax) begin
      age_d = age_q + 8'd1;
    end else begin
      age_d = age_q;
    end
    stable_d = stable_q;
    held_rel = held_q;
    if (age_d > limit_i && raw_i != stable_q) begin
      stable_d = raw_i;
      if (raw_i) begin
        held_rel = 1'b0;
      end
    end
    last_d = raw_i;
    press  = !stable_d && !held_rel;
    held_d = held_rel | press;
  end

  // Advance lane state on polls only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= 1'b1;
      stable_q <= 1'b1;
      held_q   <= 1'b0;
      age_q    <= 8'd0;
    end else if (poll_i) begin
      last_q   <= last_d;
      stable_q <= stable_d;
      held_q   <= held_d;
      age_q    <= age_d;
    end
  end

  assign status_o.press  = poll_i & press;
  assign status_o.stable = poll_i ? stable_d : stable_q;

endmodule

/* design/dsc_count_core.sv */
// Merging stage: applies lane presses and ticks to the count, forms BCD digits.
module dsc_count_core
  import dsc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   poll_i,
  input  logic                   tick_i,
  input  logic [ButtonCount-1:0] press_i,
  output count_digits_t          digits_o
);

  logic [5:0] sec_q, sec_d;
  logic [4:0] frac_q, frac_d;
  logic [4:0] ticks_q, ticks_d;
  logic       run_q, run_d;
  logic [2:0] tens;

  // Next count: presses in button order on polls, advance on ticks
  always_comb begin
    sec_d   = sec_q;
    frac_d  = frac_q;
    ticks_d = ticks_q;
    run_d   = run_q;
    if (poll_i) begin
      if (press_i[BtnInc]) begin
        if (sec_d >= SecMax) begin
          sec_d  = 6'd0;
          frac_d = 5'd0;
        end else begin
          sec_d = sec_d + 6'd1;
        end
      end
      if (press_i[BtnDec]) begin
        if (sec_d == 6'd0) begin
          sec_d = SecMax;
        end else begin
          sec_d = sec_d - 6'd1;
        end
      end
      if (press_i[BtnClear]) begin
        sec_d  = 6'd0;
        frac_d = 5'd0;
      end
      if (press_i[BtnToggle]) begin
        run_d = !run_d;
      end
    end else if (tick_i) begin
      if (run_q) begin
        ticks_d = ticks_d + 5'd1;
        frac_d  = frac_d + 5'd1;
      end
      if (ticks_d >= TicksPerSec) begin
        ticks_d = 5'd0;
        frac_d  = 5'd0;
        if (sec_d >= SecMax) begin
          sec_d = 6'd0;
        end else begin
          sec_d = sec_d + 6'd1;
        end
      end
    end
    // Guard the fraction and seconds ranges
    if (frac_d >= TicksPerSec) begin
      frac_d = 5'd0;
    end
    if (sec_d > SecMax) begin
      sec_d = 6'd0;
    end
  end

  // Hold count state between items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_q   <= 6'd0;
      frac_q  <= 5'd0;
      ticks_q <= 5'd0;
      run_q   <= 1'b0;
    end else if (poll_i || tick_i) begin
      sec_q   <= sec_d;
      frac_q  <= frac_d;
      ticks_q <= ticks_d;
      run_q   <= run_d;
    end
  end

  // BCD of the updated count; a step is five hundredths
  always_comb begin
    tens                      = sec_tens(sec_d);
    digits_o.seconds_tens     = tens;
    digits_o.seconds_ones     = 4'(sec_d - 6'(tens) * 6'd10);
    digits_o.tenths_digit     = 4'(frac_d >> 1);
    digits_o.hundredths_digit = frac_d[0] ? 4'd5 : 4'd0;
    digits_o.running          = run_d;
  end

endmodule

/* design/debounced_stopwatch_control.sv */
// Top level: four debounce lanes, count merge, and a two-entry result buffer.
// A result is held in the result register, or in the skid entry while the output stalls.
// Throughput: one item per cycle; the input stalls only when both the result
// register and the skid entry are full.
// Reset (rst_ni low, asynchronous): buttons released, ages and count cleared,
// stopped, debounce limit back to 5, result buffer empty.
module debounced_stopwatch_control
  import dsc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i,
  dsc_in_if.sink     in_i,
  dsc_out_if.source  out_o
);

  logic [7:0]             limit_q;
  logic                   accept;
  logic                   poll;
  logic                   tick;
  lane_status_t           lane_status [ButtonCount];
  logic [ButtonCount-1:0] press;
  logic [ButtonCount-1:0] stable;
  count_digits_t          digits;
  result_t                result_new;
  result_t                out_q;
  result_t                skid_q;
  logic                   out_valid_q;
  logic                   skid_valid_q;
  logic                   out_taken;

  // Hold the debounce limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_data_i;
    end
  end

  assign in_i.ready = !skid_valid_q;
  assign accept     = in_i.valid && !skid_valid_q;
  assign poll       = accept && (in_i.op == OpPoll);
  assign tick       = accept && (in_i.op == OpTick);

  // One debounce lane per button
  for (genvar b = 0; b < ButtonCount; b++) begin : g_lane
    dsc_debounce_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .poll_i   (poll),
      .raw_i    (in_i.raw_buttons[b]),
      .limit_i  (limit_q),
      .status_o (lane_status[b])
    );
    assign press[b]  = lane_status[b].press;
    assign stable[b] = lane_status[b].stable;
  end

  dsc_count_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .poll_i   (poll),
    .tick_i   (tick),
    .press_i  (press),
    .digits_o (digits)
  );

  assign result_new.digits         = digits;
  assign result_new.stable_buttons = stable;

  assign out_taken = out_valid_q && out_o.ready;

  // Result register with skid entry behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_taken || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Move payloads alongside the valid bits
  always_ff @(posedge clk_i) begin
    if (out_taken || !out_valid_q) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= result_new;
      end
    end else if (accept) begin
      skid_q <= result_new;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.seconds_tens     = out_q.digits.seconds_tens;
  assign out_o.seconds_ones     = out_q.digits.seconds_ones;
  assign out_o.tenths_digit     = out_q.digits.tenths_digit;
  assign out_o.hundredths_digit = out_q.digits.hundredths_digit;
  assign out_o.running          = out_q.digits.running;
  assign out_o.stable_buttons   = out_q.stable_buttons;

endmodule
